[hdl/svt_pkg.sv]
// ============================================================================
// svt_pkg: shared types and constants of the sorted value table
// Field widths, operation and status codes, and the compare result type.
// ============================================================================
package svt_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int DATA_W       = 32;
    localparam int FUNC_W       = 2;
    localparam int STATUS_W     = 2;
    localparam int FILL_W       = 6;

    // Operation codes carried by a request.
    localparam logic [FUNC_W-1:0] FUNC_INSERT    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LIST_ASC  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_LIST_DESC = 2'd3;

    // Status codes carried by a result.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd3;

    // Outcome of the shared signed comparator.
    typedef struct packed {
        logic lt;   // stored entry is less than the request value
        logic eq;   // stored entry equals the request value
    } cmp_t;

endpackage

[hdl/svt_ram.sv]
// ============================================================================
// svt_ram: entry store of the sorted value table
// One write port and one read port; read data is registered.
// ============================================================================
module svt_ram #(
    parameter int DEPTH = svt_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [svt_pkg::DATA_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [svt_pkg::DATA_W-1:0] rd_data
);

    logic [svt_pkg::DATA_W-1:0] mem [DEPTH];
    logic [svt_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/svt_cmp.sv]
// ============================================================================
// svt_cmp: shared signed comparator of the sorted value table
// Compares a stored entry against the request value for the insert and delete walks.
// ============================================================================
module svt_cmp (
    input  logic signed [svt_pkg::DATA_W-1:0] entry,
    input  logic signed [svt_pkg::DATA_W-1:0] key,
    output svt_pkg::cmp_t                     result
);

    always_comb
    begin
        result.lt = (entry < key);
        result.eq = (entry == key);
    end

endmodule

[hdl/sorted_value_table_core.sv]
// ============================================================================
// sorted_value_table_core: ordered table of signed 32-bit values
// Sequencer that inserts, deletes and lists entries kept in ascending order.
// ============================================================================
//
// Usage: a request (func, value) is taken on req_valid & req_ready. Insert
// places the value after all entries that are not greater; delete removes one
// equal entry; listings return every entry in ascending or descending order.
// Results leave on res_valid/res_ready, and last_result marks the final
// result of a request. Insert and delete give exactly one result.
//
// Structure: one sequencer walks the entry memory through a single read port
// and a single shared comparator; each visited entry takes a read state and
// a compare or output state because the memory read data is registered.
// req_ready is high only while the sequencer is idle, so one request is in
// flight at a time.
//
// Reset empties the table at once; no clearing pass is needed because only
// entries below the fill count are ever read. A stalled receiver holds the
// result register, and the sequencer waits before writing the next result.
// ============================================================================
module sorted_value_table_core #(
    parameter int CAPACITY = svt_pkg::CAPACITY_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  logic [svt_pkg::FUNC_W-1:0]         func,
    input  logic signed [svt_pkg::DATA_W-1:0]  value,
    output logic                               res_valid,
    input  logic                               res_ready,
    output logic signed [svt_pkg::DATA_W-1:0]  entry_value,
    output logic [svt_pkg::STATUS_W-1:0]       status,
    output logic [svt_pkg::FILL_W-1:0]         fill_count,
    output logic                               last_result
);

    // Address width covers the entries; count width can also hold CAPACITY.
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(CAPACITY);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_INS_RD  = 3'd1;
    localparam logic [2:0] ST_INS_CMP = 3'd2;
    localparam logic [2:0] ST_DEL_RD  = 3'd3;
    localparam logic [2:0] ST_DEL_CMP = 3'd4;
    localparam logic [2:0] ST_LST_RD  = 3'd5;
    localparam logic [2:0] ST_LST_OUT = 3'd6;
    localparam logic [2:0] ST_FINISH  = 3'd7;

    logic [2:0]                       state_reg, state_next;
    logic [svt_pkg::FUNC_W-1:0]       func_reg, func_next;
    logic signed [svt_pkg::DATA_W-1:0] value_reg, value_next;
    logic [svt_pkg::STATUS_W-1:0]     status_reg, status_next;
    logic [CW-1:0]                    idx_reg, idx_next;
    logic [CW-1:0]                    count_reg, count_next;
    logic                             found_reg, found_next;

    logic                             res_valid_reg, res_valid_next;
    logic signed [svt_pkg::DATA_W-1:0] res_value_reg, res_value_next;
    logic [svt_pkg::STATUS_W-1:0]     res_status_reg, res_status_next;
    logic [svt_pkg::FILL_W-1:0]       res_fill_reg, res_fill_next;
    logic                             res_last_reg, res_last_next;

    // Memory port signals.
    logic                             wr_en;
    logic [CW-1:0]                    wr_idx;
    logic signed [svt_pkg::DATA_W-1:0] wr_data;
    logic                             rd_en;
    logic [CW-1:0]                    rd_idx;
    logic signed [svt_pkg::DATA_W-1:0] rd_data;

    logic [CW-1:0]                    idx_dec;
    logic [CW-1:0]                    idx_inc;
    logic [CW-1:0]                    idx_rev;
    logic                             res_free;
    svt_pkg::cmp_t                    cmp;

    assign idx_dec  = idx_reg - CW'(1);
    assign idx_inc  = idx_reg + CW'(1);
    assign idx_rev  = count_reg - CW'(1) - idx_reg;
    assign res_free = !res_valid_reg || res_ready;

    svt_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_idx[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_idx[AW-1:0]),
        .rd_data (rd_data)
    );

    // The single comparator used by the insert and delete walks.
    svt_cmp u_cmp (
        .entry  (rd_data),
        .key    (value_reg),
        .result (cmp)
    );

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        value_next      = value_reg;
        status_next     = status_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        found_next      = found_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        res_fill_next   = res_fill_reg;
        res_last_next   = res_last_reg;
        res_valid_next  = res_valid_reg && !res_ready;
        wr_en           = 1'b0;
        wr_idx          = idx_reg;
        wr_data         = value_reg;
        rd_en           = 1'b0;
        rd_idx          = idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    func_next   = func;
                    value_next  = value;
                    status_next = svt_pkg::STATUS_OK;
                    found_next  = 1'b0;
                    case (func)
                        svt_pkg::FUNC_INSERT:
                        begin
                            idx_next = count_reg;
                            if (count_reg >= COUNT_MAX)
                            begin
                                status_next = svt_pkg::STATUS_FULL;
                                state_next  = ST_FINISH;
                            end
                            else
                            begin
                                state_next = ST_INS_RD;
                            end
                        end
                        svt_pkg::FUNC_DELETE:
                        begin
                            idx_next   = '0;
                            state_next = ST_DEL_RD;
                        end
                        default:
                        begin
                            idx_next = '0;
                            if (count_reg == '0)
                            begin
                                value_next  = '0;
                                status_next = svt_pkg::STATUS_EMPTY;
                                state_next  = ST_FINISH;
                            end
                            else
                            begin
                                state_next = ST_LST_RD;
                            end
                        end
                    endcase
                end
            end

            // Insert walks down from the top, moving larger entries up.
            ST_INS_RD:
            begin
                if (idx_reg == '0)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CW'(1);
                    state_next = ST_FINISH;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_idx     = idx_dec;
                    state_next = ST_INS_CMP;
                end
            end

            ST_INS_CMP:
            begin
                wr_en = 1'b1;
                if (!cmp.lt && !cmp.eq)
                begin
                    wr_data    = rd_data;
                    idx_next   = idx_dec;
                    state_next = ST_INS_RD;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                    state_next = ST_FINISH;
                end
            end

            // Delete searches upward; after the match each entry moves down.
            ST_DEL_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    if (found_reg)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                    else
                    begin
                        status_next = svt_pkg::STATUS_NOT_FOUND;
                    end
                    state_next = ST_FINISH;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = ST_DEL_CMP;
                end
            end

            ST_DEL_CMP:
            begin
                if (found_reg)
                begin
                    wr_en      = 1'b1;
                    wr_idx     = idx_dec;
                    wr_data    = rd_data;
                    idx_next   = idx_inc;
                    state_next = ST_DEL_RD;
                end
                else if (cmp.lt)
                begin
                    idx_next   = idx_inc;
                    state_next = ST_DEL_RD;
                end
                else if (cmp.eq)
                begin
                    found_next = 1'b1;
                    idx_next   = idx_inc;
                    state_next = ST_DEL_RD;
                end
                else
                begin
                    status_next = svt_pkg::STATUS_NOT_FOUND;
                    state_next  = ST_FINISH;
                end
            end

            ST_LST_RD:
            begin
                rd_en      = 1'b1;
                rd_idx     = (func_reg == svt_pkg::FUNC_LIST_ASC) ? idx_reg : idx_rev;
                state_next = ST_LST_OUT;
            end

            // The read data register holds while the receiver stalls.
            ST_LST_OUT:
            begin
                if (res_free)
                begin
                    res_valid_next  = 1'b1;
                    res_value_next  = rd_data;
                    res_status_next = svt_pkg::STATUS_OK;
                    res_fill_next   = svt_pkg::FILL_W'(count_reg);
                    res_last_next   = (idx_inc == count_reg);
                    idx_next        = idx_inc;
                    state_next      = (idx_inc == count_reg) ? ST_IDLE : ST_LST_RD;
                end
            end

            ST_FINISH:
            begin
                if (res_free)
                begin
                    res_valid_next  = 1'b1;
                    res_value_next  = value_reg;
                    res_status_next = status_reg;
                    res_fill_next   = svt_pkg::FILL_W'(count_reg);
                    res_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            found_reg     <= 1'b0;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            found_reg     <= found_next;
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        value_reg      <= value_next;
        status_reg     <= status_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        res_fill_reg   <= res_fill_next;
        res_last_reg   <= res_last_next;
    end

    assign req_ready   = (state_reg == ST_IDLE);
    assign res_valid   = res_valid_reg;
    assign entry_value = res_value_reg;
    assign status      = res_status_reg;
    assign fill_count  = res_fill_reg;
    assign last_result = res_last_reg;

    // The table never holds more than its capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_MAX)
        else $error("entry count exceeds capacity");

    // The count moves by at most one entry per operation step.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |->
            (count_reg == $past(count_reg) + CW'(1)) ||
            (count_reg + CW'(1) == $past(count_reg)))
        else $error("entry count jumped by more than one");

    // During a delete, entries are only moved once the match was seen.
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && state_reg == ST_DEL_CMP) |-> found_reg)
        else $error("delete wrote before finding its match");

    // Every write lands inside the table.
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (wr_idx < COUNT_MAX))
        else $error("write address beyond capacity");

    // A new result is never loaded over one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_ready) |=> $stable(res_value_reg) && $stable(res_last_reg))
        else $error("pending result overwritten");

endmodule
